>>> rtl/wwkc_pkg.sv
// Shared types and constants for the whole-word keyword counter.
package wwkc_pkg;

    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_TEXT   = 2'd1,
        OP_FINISH = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ENDW,
        S_REPORT,
        S_FIN_RD,
        S_FIN_CHK,
        S_FIN_END
    } t_state;

    localparam logic       KIND_LINE = 1'b0;
    localparam logic       KIND_BEST = 1'b1;
    localparam int         MAX_OUT   = 32;
    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [7:0] CASE_GAP  = 8'd32;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [4:0] IDX_OVER  = 5'd31;

    // controller -> datapath
    typedef struct packed {
        logic kw_write;
        logic latch_text;
        logic letter_skip;
        logic match_step;
        logic end_word;
        logic report;
        logic fin_start;
        logic fin_step;
        logic fin_close;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_letter;
        logic word_full;
        logic last_q;
        logic out_free;
        logic fin_done;
        logic fin_hit;
        logic fin_pend;
    } t_sts;

endpackage

>>> rtl/wwkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wwkc_ram #(
    parameter  int W  = 8,
    parameter  int D  = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/wwkc_ctrl.sv
// Sequencing state machine for the whole-word keyword counter.
module wwkc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_opcode,
    input  logic          i_last,
    output logic          o_ready,
    input  wwkc_pkg::t_sts i_sts,
    output wwkc_pkg::t_cmd o_cmd
);
    wwkc_pkg::t_state r_state;
    wwkc_pkg::t_state n_state;
    wwkc_pkg::t_op    op;
    logic             take;

    assign op      = wwkc_pkg::t_op'(i_opcode);
    assign o_ready = (r_state == wwkc_pkg::S_IDLE);
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wwkc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wwkc_pkg::S_IDLE: begin
                if (take) begin
                    case (op)
                        wwkc_pkg::OP_TEXT: begin
                            if (!i_sts.in_letter) begin
                                n_state = wwkc_pkg::S_ENDW;
                            end else if (!i_sts.word_full) begin
                                n_state = wwkc_pkg::S_MATCH;
                            end else if (i_last) begin
                                n_state = wwkc_pkg::S_ENDW;
                            end
                        end
                        wwkc_pkg::OP_FINISH: n_state = wwkc_pkg::S_FIN_RD;
                        default:             n_state = wwkc_pkg::S_IDLE;
                    endcase
                end
            end
            wwkc_pkg::S_MATCH:
                n_state = i_sts.last_q ? wwkc_pkg::S_ENDW : wwkc_pkg::S_IDLE;
            wwkc_pkg::S_ENDW:
                n_state = i_sts.last_q ? wwkc_pkg::S_REPORT : wwkc_pkg::S_IDLE;
            wwkc_pkg::S_REPORT: begin
                if (i_sts.out_free) n_state = wwkc_pkg::S_IDLE;
            end
            wwkc_pkg::S_FIN_RD:
                n_state = i_sts.fin_done ? wwkc_pkg::S_FIN_END : wwkc_pkg::S_FIN_CHK;
            wwkc_pkg::S_FIN_CHK: begin
                if (!(i_sts.fin_hit && i_sts.fin_pend && !i_sts.out_free))
                    n_state = wwkc_pkg::S_FIN_RD;
            end
            wwkc_pkg::S_FIN_END: begin
                if (!(i_sts.fin_pend && !i_sts.out_free)) n_state = wwkc_pkg::S_IDLE;
            end
            default: n_state = wwkc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            wwkc_pkg::S_IDLE: begin
                if (take) begin
                    case (op)
                        wwkc_pkg::OP_KEY:    o_cmd.kw_write = 1'b1;
                        wwkc_pkg::OP_TEXT: begin
                            o_cmd.latch_text  = 1'b1;
                            o_cmd.letter_skip = i_sts.in_letter && i_sts.word_full;
                        end
                        wwkc_pkg::OP_FINISH: o_cmd.fin_start = 1'b1;
                        default:             o_cmd = '0;
                    endcase
                end
            end
            wwkc_pkg::S_MATCH:  o_cmd.match_step = 1'b1;
            wwkc_pkg::S_ENDW:   o_cmd.end_word = 1'b1;
            wwkc_pkg::S_REPORT: o_cmd.report = i_sts.out_free;
            wwkc_pkg::S_FIN_CHK:
                o_cmd.fin_step = !(i_sts.fin_hit && i_sts.fin_pend && !i_sts.out_free);
            wwkc_pkg::S_FIN_END:
                o_cmd.fin_close = !(i_sts.fin_pend && !i_sts.out_free);
            default: o_cmd = '0;
        endcase
    end
endmodule

>>> rtl/wwkc_dp.sv
// Datapath: keyword stores, word match flags, line counts, result register.
module wwkc_dp #(
    parameter int NUM_KEYWORDS = 32,
    parameter int KEY_LEN      = 32,
    parameter int MAX_LINES    = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wwkc_pkg::t_cmd i_cmd,
    output wwkc_pkg::t_sts o_sts,
    input  logic [7:0]     i_data_byte,
    input  logic [4:0]     i_slot,
    input  logic [4:0]     i_position,
    input  logic           i_last,
    input  logic           i_cfg_we,
    input  logic [5:0]     i_cfg_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [4:0]     o_line_index,
    output logic [7:0]     o_count,
    output logic           o_last_result
);
    localparam int AW      = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int LW      = $clog2(KEY_LEN + 1);
    localparam int HW      = $clog2(NUM_KEYWORDS + 1);
    localparam int LINE_W  = $clog2(MAX_LINES + 1);
    localparam int LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [7:0]        folded;
    logic              slot_ok;
    logic [5:0]        r_kc;
    logic [7:0]        r_char;
    logic              r_last;
    logic [LW-1:0]     r_wl;
    logic              r_too_long;
    logic [NUM_KEYWORDS-1:0] r_sm;
    logic [NUM_KEYWORDS-1:0] hit_vec;
    logic [HW-1:0]     hits;
    logic [8:0]        sum;
    logic [7:0]        r_running;
    logic [7:0]        r_best;
    logic [LINE_W-1:0] r_cur;
    logic              cur_ok;
    logic [LINE_W-1:0] r_fin_idx;
    logic [LINE_W-1:0] r_pend_idx;
    logic              r_pend;
    logic [5:0]        r_nres;
    logic [7:0]        line_rdata;
    logic              fin_hit;
    logic              out_load;
    logic              r_out_valid;
    logic              r_kind;
    logic [4:0]        r_idx;
    logic [7:0]        r_cnt;
    logic              r_lastr;
    logic              word_clear;

    assign folded = (i_data_byte >= wwkc_pkg::CH_UP_A && i_data_byte <= wwkc_pkg::CH_UP_Z)
                    ? i_data_byte + wwkc_pkg::CASE_GAP : i_data_byte;
    assign slot_ok = (7'(i_slot) < 7'(NUM_KEYWORDS)) && (7'(i_position) < 7'(KEY_LEN));
    assign word_clear = i_cmd.end_word || i_cmd.fin_close;

    // per-slot character store, length and match flag
    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
        logic [7:0]    rd;
        logic [LW-1:0] r_len;
        logic          we;

        assign we = i_cmd.kw_write && slot_ok && (7'(i_slot) == 7'(k));

        wwkc_ram #(.W(8), .D(KEY_LEN)) u_chars (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(AW'(i_position)),
            .i_wdata(folded),
            .i_raddr(AW'(r_wl)),
            .o_rdata(rd)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_len   <= '0;
                r_sm[k] <= 1'b1;
            end else begin
                if (we && i_last) r_len <= LW'(i_position) + LW'(1);
                if (word_clear) begin
                    r_sm[k] <= 1'b1;
                end else if (i_cmd.match_step) begin
                    r_sm[k] <= r_sm[k] && (r_wl < r_len) && (rd == r_char);
                end
            end
        end

        assign hit_vec[k] = r_sm[k] && (r_len == r_wl) && (7'(r_kc) > 7'(k));
    end

    assign hits = HW'($countones(hit_vec));
    assign sum  = 9'(r_running) + 9'(hits);

    // line counts
    assign cur_ok = r_cur < LINE_W'(MAX_LINES);

    wwkc_ram #(.W(8), .D(MAX_LINES)) u_lines (
        .i_clk  (i_clk),
        .i_we   (i_cmd.report && cur_ok),
        .i_waddr(LINE_AW'(r_cur)),
        .i_wdata(r_running),
        .i_raddr(LINE_AW'(r_fin_idx)),
        .o_rdata(line_rdata)
    );

    assign fin_hit = (line_rdata == r_best) && (r_nres < 6'(wwkc_pkg::MAX_OUT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kc       <= '0;
            r_wl       <= '0;
            r_too_long <= 1'b0;
            r_running  <= '0;
            r_best     <= '0;
            r_cur      <= '0;
            r_fin_idx  <= '0;
            r_pend     <= 1'b0;
            r_nres     <= '0;
            r_last     <= 1'b0;
        end else begin
            if (i_cfg_we) r_kc <= i_cfg_data;
            if (i_cmd.latch_text) r_last <= i_last;
            if (i_cmd.letter_skip) r_too_long <= 1'b1;
            if (i_cmd.match_step) r_wl <= r_wl + LW'(1);
            if (i_cmd.end_word) begin
                if (r_wl != '0 && !r_too_long)
                    r_running <= sum[8] ? wwkc_pkg::COUNT_MAX : sum[7:0];
            end
            if (word_clear) begin
                r_wl       <= '0;
                r_too_long <= 1'b0;
            end
            if (i_cmd.report) begin
                r_running <= '0;
                if (cur_ok) begin
                    r_cur <= r_cur + LINE_W'(1);
                    if (r_running > r_best) r_best <= r_running;
                end
            end
            if (i_cmd.fin_start) begin
                r_fin_idx <= '0;
                r_pend    <= 1'b0;
                r_nres    <= '0;
            end
            if (i_cmd.fin_step) begin
                r_fin_idx <= r_fin_idx + LINE_W'(1);
                if (fin_hit) begin
                    r_pend <= 1'b1;
                    r_nres <= r_nres + 6'd1;
                end
            end
            if (i_cmd.fin_close) begin
                r_cur     <= '0;
                r_best    <= '0;
                r_running <= '0;
                r_pend    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_text) r_char <= folded;
        if (i_cmd.fin_step && fin_hit) r_pend_idx <= r_fin_idx;
    end

    // result register
    assign out_load = i_cmd.report || (i_cmd.fin_step && fin_hit && r_pend)
                      || (i_cmd.fin_close && r_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_kind  <= wwkc_pkg::KIND_LINE;
            r_idx   <= cur_ok ? 5'(r_cur) : wwkc_pkg::IDX_OVER;
            r_cnt   <= r_running;
            r_lastr <= 1'b1;
        end else if (out_load) begin
            r_kind  <= wwkc_pkg::KIND_BEST;
            r_idx   <= 5'(r_pend_idx);
            r_cnt   <= r_best;
            r_lastr <= i_cmd.fin_close;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_line_index  = r_idx;
    assign o_count       = r_cnt;
    assign o_last_result = r_lastr;

    assign o_sts.in_letter = (folded >= wwkc_pkg::CH_LO_A) && (folded <= wwkc_pkg::CH_LO_Z);
    assign o_sts.word_full = r_too_long || (r_wl >= LW'(KEY_LEN));
    assign o_sts.last_q    = r_last;
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_sts.fin_done  = (r_fin_idx == r_cur);
    assign o_sts.fin_hit   = fin_hit;
    assign o_sts.fin_pend  = r_pend;
endmodule

>>> rtl/whole_word_keyword_counter.sv
// Top level of the whole-word keyword counter.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  input     | i_valid / o_ready  | opcode, data_byte, slot, position, last
//  result    | o_valid / i_ready  | kind, line_index, count, last_result
//  config    | i_cfg_we           | i_cfg_data = keyword_count
//
// Steps: a keyword load or an ignored opcode is handled when it is taken. A text
// letter is latched, then the keyword store is read and compared in all slots
// (S_MATCH); a word end adds S_ENDW, and a line end adds S_REPORT. Finish walks the
// line-count RAM through S_FIN_RD and S_FIN_CHK per stored line, then S_FIN_END.
// Reset is synchronous; no clearing pass is needed after it.
// A result transaction waits in the output register; a new input transaction
// is taken meanwhile and stalls only when it must load a second result.
module whole_word_keyword_counter #(
    parameter int NUM_KEYWORDS = 32,
    parameter int KEY_LEN      = 32,
    parameter int MAX_LINES    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic [4:0] i_slot,
    input  logic [4:0] i_position,
    input  logic       i_last,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [4:0] o_line_index,
    output logic [7:0] o_count,
    output logic       o_last_result
);
    wwkc_pkg::t_cmd cmd;
    wwkc_pkg::t_sts sts;

    // sequencer: decodes each transaction, steps match / word end / report / finish walk
    wwkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_opcode(i_opcode),
        .i_last  (i_last),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // per-slot stores and flags, line counts, result register
    wwkc_dp #(
        .NUM_KEYWORDS(NUM_KEYWORDS),
        .KEY_LEN     (KEY_LEN),
        .MAX_LINES   (MAX_LINES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_data_byte  (i_data_byte),
        .i_slot       (i_slot),
        .i_position   (i_position),
        .i_last       (i_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_line_index (o_line_index),
        .o_count      (o_count),
        .o_last_result(o_last_result)
    );
endmodule

>>> rtl/wwkc_checker.sv
// Port-level checks for the whole-word keyword counter, bound to the top level.
module wwkc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_kind,
    input logic [4:0] o_line_index,
    input logic [7:0] o_count,
    input logic       o_last_result
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_count) && $stable(o_line_index))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == wwkc_pkg::KIND_LINE) |-> o_last_result)
        else $error("line report not marked last");

    a_best_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_result && (o_kind == wwkc_pkg::KIND_BEST)
        ##1 o_valid |-> (o_kind == wwkc_pkg::KIND_BEST) && $stable(o_count))
        else $error("best-line list broken or count changed");
endmodule

bind whole_word_keyword_counter wwkc_checker u_wwkc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_line_index (o_line_index),
    .o_count      (o_count),
    .o_last_result(o_last_result)
);

>>> bench/tb.sv
// Testbench for the whole-word keyword counter: scoreboard plus directed and random stimulus.
`timescale 1ns / 100ps

class wwkc_scoreboard;
    // Mirror of the block's state.
    logic [7:0] key_chars [32][32];
    logic [5:0] key_len [32];
    bit         alive [32];
    int         word_len;
    bit         word_long;
    logic [7:0] line_cnt [32];
    int         cur_line;
    int         best;
    int         running;
    int         kw_used;
    // Pending results: {kind, line_index, count, last_result}.
    logic [14:0] pending_results [$];
    int          mismatches;

    function new();
        foreach (key_len[k]) key_len[k] = 0;
        foreach (line_cnt[l]) line_cnt[l] = 0;
        foreach (key_chars[k, p]) key_chars[k][p] = 0;
        clear_word();
        cur_line = 0;
        best = 0;
        running = 0;
        kw_used = 0;
        mismatches = 0;
    endfunction

    function void set_keyword_count(logic [5:0] v);
        kw_used = (v > 32) ? 32 : v;
    endfunction

    function void clear_word();
        word_len = 0;
        word_long = 0;
        foreach (alive[k]) alive[k] = 1;
    endfunction

    function void close_word();
        if (word_len > 0 && !word_long)
            for (int k = 0; k < kw_used; k++)
                if (alive[k] && key_len[k] == word_len && running < 255) running++;
        clear_word();
    endfunction

    function void push_letter(logic [7:0] c);
        if (word_long) return;
        if (word_len >= 32) begin
            word_long = 1;
            return;
        end
        for (int k = 0; k < 32; k++)
            if (alive[k] && (word_len >= key_len[k] || key_chars[k][word_len] != c))
                alive[k] = 0;
        word_len++;
    endfunction

    // Note one accepted input transaction.
    function void note_input(wwkc_pkg::t_op op, logic [7:0] b, logic [4:0] slot,
                             logic [4:0] pos, logic lst);
        logic [7:0] c;
        int         n;
        c = (b >= wwkc_pkg::CH_UP_A && b <= wwkc_pkg::CH_UP_Z) ? b + wwkc_pkg::CASE_GAP : b;
        case (op)
            wwkc_pkg::OP_KEY: begin
                key_chars[slot][pos] = c;
                if (lst) key_len[slot] = 6'(pos) + 6'd1;
            end
            wwkc_pkg::OP_TEXT: begin
                if (c >= wwkc_pkg::CH_LO_A && c <= wwkc_pkg::CH_LO_Z) push_letter(c);
                else close_word();
                if (lst) begin
                    close_word();
                    if (cur_line < 32) begin
                        line_cnt[cur_line] = 8'(running);
                        if (running > best) best = running;
                        pending_results.push_back({wwkc_pkg::KIND_LINE, 5'(cur_line),
                                                   8'(running), 1'b1});
                        cur_line++;
                    end else begin
                        pending_results.push_back({wwkc_pkg::KIND_LINE, wwkc_pkg::IDX_OVER,
                                                   8'(running), 1'b1});
                    end
                    running = 0;
                end
            end
            wwkc_pkg::OP_FINISH: begin
                n = 0;
                for (int i = 0; i < cur_line && i < 32; i++)
                    if (line_cnt[i] == best) begin
                        pending_results.push_back({wwkc_pkg::KIND_BEST, 5'(i), 8'(best), 1'b0});
                        n++;
                    end
                if (n > 0) pending_results[$][0] = 1'b1;
                foreach (line_cnt[l]) line_cnt[l] = 0;
                cur_line = 0;
                best = 0;
                running = 0;
                clear_word();
            end
            default: ;
        endcase
    endfunction

    // Check one accepted result transaction against the oldest expectation.
    function void check_result(logic kind, logic [4:0] idx, logic [7:0] cnt, logic lst);
        logic [14:0] want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result kind=%0d idx=%0d count=%0d last=%0d",
                         kind, idx, cnt, lst);
            return;
        end
        want = pending_results.pop_front();
        if (want != {kind, idx, cnt, lst}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp kind=%0d idx=%0d count=%0d last=%0d, got %0d %0d %0d %0d",
                         want[14], want[13:9], want[8:1], want[0], kind, idx, cnt, lst);
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [1:0] in_op = 0;
    logic [7:0] in_byte = 0;
    logic [4:0] in_slot = 0;
    logic [4:0] in_pos = 0;
    logic       in_last = 0;
    logic       cfg_we = 0;
    logic [5:0] cfg_data = 0;
    logic       res_valid;
    logic       res_ready = 0;
    logic       res_kind;
    logic [4:0] res_idx;
    logic [7:0] res_count;
    logic       res_last;

    // Idle percentages for each side; a long hold-off overrides the receiver.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 0;
    int  quiet_cycles = 0;
    bit  timed_out = 0;

    wwkc_scoreboard sb;

    // Working keyword set, so most text forms real matches.
    string vocab [8];

    always #10 clk = ~clk;

    whole_word_keyword_counter u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_opcode     (in_op),
        .i_data_byte  (in_byte),
        .i_slot       (in_slot),
        .i_position   (in_pos),
        .i_last       (in_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_valid      (res_valid),
        .i_ready      (res_ready),
        .o_kind       (res_kind),
        .o_line_index (res_idx),
        .o_count      (res_count),
        .o_last_result(res_last)
    );

    // Receiver: random stalls, or a long hold-off while recv_hold is set.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_kind, res_idx, res_count, res_last);
        res_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Send one input transaction; valid stays high across back-to-back items.
    task automatic send_item(wwkc_pkg::t_op op, logic [7:0] b, logic [4:0] slot,
                             logic [4:0] pos, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_op    <= op;
        in_byte  <= b;
        in_slot  <= slot;
        in_pos   <= pos;
        in_last  <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, b, slot, pos, lst);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
        @(posedge clk);
    endtask

    // Wait for all expectations, then a further wait for a word still being matched.
    task automatic wait_drained();
        drop_valid();
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_keyword_count(logic [5:0] v);
        wait_drained();
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_keyword_count(v);
    endtask

    // Load a keyword, randomly flipping letter case.
    task automatic load_keyword(int slot, string w);
        byte c;
        for (int p = 0; p < w.len(); p++) begin
            c = w[p];
            if ($urandom_range(1) && c >= "a" && c <= "z") c = c - 8'd32;
            send_item(wwkc_pkg::OP_KEY, c, 5'(slot), 5'(p), p == w.len() - 1);
        end
    endtask

    task automatic send_text(string s, bit end_line);
        byte c;
        for (int p = 0; p < s.len(); p++) begin
            c = s[p];
            if ($urandom_range(3) == 0 && c >= "a" && c <= "z") c = c - 8'd32;
            send_item(wwkc_pkg::OP_TEXT, c, 5'($urandom), 5'($urandom),
                      end_line && p == s.len() - 1);
        end
    endtask

    // One random line built mostly from vocabulary words.
    task automatic random_line();
        int    nw;
        string s;
        nw = $urandom_range(4);
        s = "";
        for (int i = 0; i < nw; i++) begin
            case ($urandom_range(9))
                0: s = {s, "zq"};
                1: s = {s, vocab[$urandom_range(7)], vocab[$urandom_range(7)]};
                default: s = {s, vocab[$urandom_range(7)]};
            endcase
            s = {s, ($urandom_range(3) == 0) ? "." : " "};
        end
        if ($urandom_range(5) == 0)
            send_text(s, 0);
        else if (s.len() > 0)
            send_text(s, 1);
        else
            send_item(wwkc_pkg::OP_TEXT, $urandom_range(1) ? "x" : " ", 0, 0, 1);
    endtask

    task automatic random_phase(int n_items, int idle, int stall);
        int start;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        start = 0;
        while (start < n_items) begin
            case ($urandom_range(19))
                0: send_item(wwkc_pkg::OP_FINISH, 8'($urandom), 5'($urandom), 5'($urandom),
                             1'($urandom));
                1: send_item(wwkc_pkg::OP_IGNORE, 8'($urandom), 5'($urandom), 5'($urandom),
                             1'($urandom));
                2: send_item(wwkc_pkg::OP_TEXT, 8'($urandom), 5'($urandom), 5'($urandom),
                             1'($urandom));
                default: random_line();
            endcase
            start += 6;
        end
        send_item(wwkc_pkg::OP_FINISH, 0, 0, 0, 0);
    endtask

    initial begin
        string long_word;
        sb = new();
        vocab = '{"a", "cat", "dog", "the", "sun", "bird", "x", "cat"};
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: keywords including a duplicate, a full-length one and an empty slot.
        long_word = "abcdefghijklmnopqrstuvwxyzabcdef";
        for (int k = 0; k < 8; k++) load_keyword(k, vocab[k]);
        load_keyword(8, long_word);
        send_item(wwkc_pkg::OP_KEY, 8'h31, 9, 0, 1);   // non-letter keyword
        send_item(wwkc_pkg::OP_KEY, 8'hff, 31, 31, 0); // top slot/position, no length
        write_keyword_count(6'd63);
        send_text("cat Dog", 1);
        send_text({long_word, " ", long_word, "g"}, 1);  // exact key length, then too long
        send_item(wwkc_pkg::OP_TEXT, 8'h00, 5'h1f, 5'h1f, 1);      // empty line
        send_item(wwkc_pkg::OP_IGNORE, 8'hff, 5'h1f, 5'h1f, 1);
        send_item(wwkc_pkg::OP_FINISH, 8'hff, 5'h1f, 5'h1f, 1);
        send_item(wwkc_pkg::OP_FINISH, 0, 0, 0, 0);                // nothing stored

        // More than the line store holds, with a long receiver hold-off.
        recv_hold = 1;
        fork
            begin
                for (int i = 0; i < 35; i++) send_text((i % 3 == 0) ? "cat" : "sun", 1);
            end
            begin
                repeat (300) @(posedge clk);
                recv_hold = 0;
            end
        join
        send_item(wwkc_pkg::OP_FINISH, 0, 0, 0, 0);

        write_keyword_count(6'd0);
        random_phase(25, 0, 0);
        write_keyword_count(6'd32);
        random_phase(40, 0, 0);
        write_keyword_count(6'd3);
        random_phase(35, 58, 0);
        write_keyword_count(6'd10);
        random_phase(35, 0, 58);
        write_keyword_count(6'd1);
        random_phase(35, 37, 37);
        write_keyword_count(6'd9);
        random_phase(30, 0, 0);

        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

>>> filelist.f
rtl/wwkc_pkg.sv
rtl/wwkc_ram.sv
rtl/wwkc_ctrl.sv
rtl/wwkc_dp.sv
rtl/whole_word_keyword_counter.sv
rtl/wwkc_checker.sv
bench/tb.sv
